// ===== src/her_pkg.sv =====
// ----------------------------------------------------------------------------
// her_pkg
// Shared widths, action codes and command/status types for the eviction
// ranker.
// ----------------------------------------------------------------------------
package her_pkg;

  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 10;
  localparam int TIME_W = 32;
  localparam int SIZE_W = 24;
  localparam int CNT_W  = 32;
  localparam int DEN_W  = TIME_W + SIZE_W;   // age * size
  localparam int PART_W = DEN_W / 2;         // denominator split for partials
  localparam int PP_W   = CNT_W + PART_W;    // one partial product
  localparam int PROD_W = CNT_W + DEN_W;     // full cross product

  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HIT     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPARE = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic accept;    // latch request payload, launch table reads
    logic ins_wr;    // write an inserted entry
    logic hit_wr;    // write back incremented hit count
    logic age_en;    // form numerators and denominators
    logic part_en;   // partial cross products
    logic sum_en;    // combine partials
    logic out_load;  // load the result register
  } her_cmd_t;

  typedef struct packed {
    logic out_busy;  // result register holds an item not taken this cycle
  } her_stat_t;

endpackage

// ===== src/her_in_if.sv =====
// ----------------------------------------------------------------------------
// her_in_if
// Request channel: valid/ready handshake with action and entry payload.
// ----------------------------------------------------------------------------
interface her_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] clock_now;
  logic [9:0]  index_a;
  logic [9:0]  index_b;
  logic [23:0] item_size;

  modport source (output valid, action, clock_now, index_a, index_b, item_size,
                  input ready);
  modport sink   (input valid, action, clock_now, index_a, index_b, item_size,
                  output ready);
endinterface

// ===== src/her_out_if.sv =====
// ----------------------------------------------------------------------------
// her_out_if
// Result channel: valid/ready handshake carrying the chosen victim.
// ----------------------------------------------------------------------------
interface her_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] victim_index;
  logic       picked_first;

  modport source (output valid, victim_index, picked_first, input ready);
  modport sink   (input valid, victim_index, picked_first, output ready);
endinterface

// ===== src/her_ctrl.sv =====
// ----------------------------------------------------------------------------
// her_ctrl
// Sequencer: accepts one request at a time and steps the datapath through
// hit write-back or the compare pipeline.
// ----------------------------------------------------------------------------
module her_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [her_pkg::ACT_W-1:0] in_action,
  output logic                     in_ready,
  input  her_pkg::her_stat_t       stat,
  output her_pkg::her_cmd_t        cmd
);
  import her_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_HIT  = 6'b000010,
    S_AGE  = 6'b000100,
    S_PART = 6'b001000,
    S_SUM  = 6'b010000,
    S_CMP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_action == ACT_HIT) state_nxt = S_HIT;
        else if (accept && in_action == ACT_COMPARE) state_nxt = S_AGE;
      end
      S_HIT:  state_nxt = S_IDLE;
      S_AGE:  state_nxt = S_PART;
      S_PART: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_CMP;
      S_CMP: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.ins_wr   = accept && (in_action == ACT_INSERT);
    cmd.hit_wr   = (state_r == S_HIT);
    cmd.age_en   = (state_r == S_AGE);
    cmd.part_en  = (state_r == S_PART);
    cmd.sum_en   = (state_r == S_SUM);
    cmd.out_load = (state_r == S_CMP) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== src/her_dp.sv =====
// ----------------------------------------------------------------------------
// her_dp
// Entry tables, priority arithmetic and result register.
// ----------------------------------------------------------------------------
module her_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  her_pkg::her_cmd_t          cmd,
  output her_pkg::her_stat_t         stat,
  input  logic [her_pkg::TIME_W-1:0] in_clock_now,
  input  logic [her_pkg::IDX_W-1:0]  in_index_a,
  input  logic [her_pkg::IDX_W-1:0]  in_index_b,
  input  logic [her_pkg::SIZE_W-1:0] in_item_size,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [her_pkg::IDX_W-1:0]  out_victim_index,
  output logic                       out_picked_first
);
  import her_pkg::*;

  logic [CNT_W-1:0]  cnt_mem [ENTRIES];
  logic [TIME_W-1:0] tim_mem [ENTRIES];
  logic [SIZE_W-1:0] siz_mem [ENTRIES];

  logic [CNT_W-1:0]  cnt_a_r, cnt_b_r;
  logic [TIME_W-1:0] tim_a_r, tim_b_r;
  logic [SIZE_W-1:0] siz_a_r, siz_b_r;

  logic [IDX_W-1:0]  idx_a_r, idx_b_r;
  logic [TIME_W-1:0] now_r;
  logic              ok_a_r, ok_b_r;

  logic [ADDR_W-1:0] in_addr_a, in_addr_b, addr_a_r;
  logic              in_ok_a, in_ok_b;

  logic              cnt_we;
  logic [ADDR_W-1:0] cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;

  logic [CNT_W-1:0]  h_a_r, h_b_r;
  logic [DEN_W-1:0]  d_a_r, d_b_r;
  logic [TIME_W-1:0] age_a, age_b;
  logic [DEN_W-1:0]  mul_a, mul_b;

  logic [PP_W-1:0]   pa_lo, pa_hi, pb_lo, pb_hi;
  logic [PP_W-1:0]   pa_lo_r, pa_hi_r, pb_lo_r, pb_hi_r;
  logic [PROD_W-1:0] prod_a_r, prod_b_r;

  logic nan_a, nan_b, inf_a, inf_b, first;
  logic out_valid_r;
  logic [IDX_W-1:0] victim_r;
  logic             picked_r;

  assign in_addr_a = ADDR_W'(in_index_a);
  assign in_addr_b = ADDR_W'(in_index_b);
  assign in_ok_a   = (32'(in_index_a) < ENTRIES);
  assign in_ok_b   = (32'(in_index_b) < ENTRIES);

  // hit count port: insert clears, hit writes back the saturated increment
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = in_addr_a;
    cnt_wdata = '0;
    if (cmd.ins_wr && in_ok_a) begin
      cnt_we = 1'b1;
    end else if (cmd.hit_wr && ok_a_r) begin
      cnt_we    = 1'b1;
      cnt_waddr = addr_a_r;
      cnt_wdata = (cnt_a_r == CNT_MAX) ? cnt_a_r : cnt_a_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cmd.accept) begin
      cnt_a_r <= cnt_mem[in_addr_a];
      cnt_b_r <= cnt_mem[in_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr && in_ok_a) tim_mem[in_addr_a] <= in_clock_now;
    if (cmd.accept) begin
      tim_a_r <= tim_mem[in_addr_a];
      tim_b_r <= tim_mem[in_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_wr && in_ok_a) siz_mem[in_addr_a] <= in_item_size;
    if (cmd.accept) begin
      siz_a_r <= siz_mem[in_addr_a];
      siz_b_r <= siz_mem[in_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_a_r  <= in_index_a;
      idx_b_r  <= in_index_b;
      addr_a_r <= in_addr_a;
      now_r    <= in_clock_now;
      ok_a_r   <= in_ok_a;
      ok_b_r   <= in_ok_b;
    end
  end

  // age wraps modulo 2^32; out-of-table entries read as zero
  assign age_a = now_r - tim_a_r;
  assign age_b = now_r - tim_b_r;
  assign mul_a = age_a * siz_a_r;
  assign mul_b = age_b * siz_b_r;

  always_ff @(posedge clk) begin
    if (cmd.age_en) begin
      h_a_r <= ok_a_r ? cnt_a_r : '0;
      h_b_r <= ok_b_r ? cnt_b_r : '0;
      d_a_r <= ok_a_r ? mul_a : '0;
      d_b_r <= ok_b_r ? mul_b : '0;
    end
  end

  // h_a * d_b and h_b * d_a, each as two half-width partials
  assign pa_lo = h_a_r * d_b_r[PART_W-1:0];
  assign pa_hi = h_a_r * d_b_r[DEN_W-1:PART_W];
  assign pb_lo = h_b_r * d_a_r[PART_W-1:0];
  assign pb_hi = h_b_r * d_a_r[DEN_W-1:PART_W];

  always_ff @(posedge clk) begin
    if (cmd.part_en) begin
      pa_lo_r <= pa_lo;
      pa_hi_r <= pa_hi;
      pb_lo_r <= pb_lo;
      pb_hi_r <= pb_hi;
    end
    if (cmd.sum_en) begin
      prod_a_r <= PROD_W'(pa_lo_r) + (PROD_W'(pa_hi_r) << PART_W);
      prod_b_r <= PROD_W'(pb_lo_r) + (PROD_W'(pb_hi_r) << PART_W);
    end
  end

  // zero denominator: 0/0 on either side picks the second, two infinities keep the first
  assign nan_a = (d_a_r == '0) && (h_a_r == '0);
  assign nan_b = (d_b_r == '0) && (h_b_r == '0);
  assign inf_a = (d_a_r == '0) && (h_a_r != '0);
  assign inf_b = (d_b_r == '0) && (h_b_r != '0);

  always_comb begin
    if (nan_a || nan_b) first = 1'b0;
    else if (inf_a)     first = inf_b;
    else if (inf_b)     first = 1'b1;
    else                first = (prod_a_r <= prod_b_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      victim_r <= first ? idx_a_r : idx_b_r;
      picked_r <= first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
  end

  assign stat.out_busy    = out_valid_r && !out_ready;
  assign out_valid        = out_valid_r;
  assign out_victim_index = victim_r;
  assign out_picked_first = picked_r;

endmodule

// ===== src/hyperbolic_eviction_ranker_top.sv =====
// ----------------------------------------------------------------------------
// hyperbolic_eviction_ranker_top
// Size-aware hyperbolic eviction ranker over a table of cache entries.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request channel (valid/ready). action 0 inserts an entry at
//            index_a (hit count cleared, clock_now and item_size stored),
//            1 records a hit at index_a (saturating), 2 compares index_a
//            with index_b; 3 is dropped.
//   out_ch : one result per compare: victim_index and picked_first, the
//            entry with the lower hits / (age * size).
//   Sequencing: one request at a time. Insert and unused actions are done
//   when accepted, a hit does a table read, then a count write-back, and a
//   compare steps through table read, age*size multiply, four partial cross
//   products, partial sum and compare, loading the result register in its
//   compare step once that register is free.
//   Reset clears the sequencer and the result valid flag; table contents
//   are undefined until an entry is inserted.
//   If the receiver stalls, the result register holds; a new insert or hit
//   is still taken, and a following compare waits in its last step until
//   the held result is taken.
// ----------------------------------------------------------------------------
module hyperbolic_eviction_ranker_top (
  input  logic      clk,
  input  logic      rst_n,
  her_in_if.sink    in_ch,
  her_out_if.source out_ch
);
  import her_pkg::*;

  her_cmd_t  cmd;
  her_stat_t stat;

  her_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  her_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_clock_now     (in_ch.clock_now),
    .in_index_a       (in_ch.index_a),
    .in_index_b       (in_ch.index_b),
    .in_item_size     (in_ch.item_size),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_victim_index (out_ch.victim_index),
    .out_picked_first (out_ch.picked_first)
  );

endmodule

// ===== tb/sv/tb_hyperbolic_eviction_ranker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hyperbolic_eviction_ranker_top
// Drives insert, hit, compare and unused requests into the eviction ranker and
// checks each victim result against a local model of the entry table.
// ----------------------------------------------------------------------------
module tb_hyperbolic_eviction_ranker_top;
  import her_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    bit               drain;   // pause until all victims are back
    logic [ACT_W-1:0] action;
    logic [TIME_W-1:0] now;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [SIZE_W-1:0] size;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] victim;
    logic             first;
  } victim_t;

  logic clk;
  logic rst_n;

  her_in_if  in_ch ();
  her_out_if out_ch ();

  hyperbolic_eviction_ranker_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // entry table as the block should hold it
  bit [CNT_W-1:0]  tbl_hits  [ENTRIES];
  bit [TIME_W-1:0] tbl_times [ENTRIES];
  bit [SIZE_W-1:0] tbl_sizes [ENTRIES];

  req_t    req_q[$];
  victim_t victim_q[$];

  // generation-side record of inserted entries
  bit              gen_written [ENTRIES];
  logic [IDX_W-1:0] live_idx[$];

  int  err_cnt   = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  drain_wait = 0;
  bit  stim_done  = 0;
  bit  req_taken  = 0;
  bit [31:0] cyc_cnt = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------- model ----------------
  function automatic bit keeps_first(bit [CNT_W-1:0] h1, bit [DEN_W-1:0] d1,
                                     bit [CNT_W-1:0] h2, bit [DEN_W-1:0] d2);
    bit [PROD_W-1:0] lhs;
    bit [PROD_W-1:0] rhs;
    // zero over zero on either side hands the pick to the second
    if ((h1 == 0 && d1 == 0) || (h2 == 0 && d2 == 0)) return 1'b0;
    if (d1 == 0) return (d2 == 0);
    if (d2 == 0) return 1'b1;
    lhs = PROD_W'(h1) * PROD_W'(d2);
    rhs = PROD_W'(h2) * PROD_W'(d1);
    return lhs <= rhs;
  endfunction

  function automatic bit [DEN_W-1:0] entry_den(logic [IDX_W-1:0] idx,
                                                logic [TIME_W-1:0] now);
    bit [TIME_W-1:0] age;
    age = now - tbl_times[idx];
    return DEN_W'(age) * DEN_W'(tbl_sizes[idx]);
  endfunction

  task automatic apply_request(logic [ACT_W-1:0] act, logic [TIME_W-1:0] now,
                               logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                               logic [SIZE_W-1:0] sz);
    victim_t v;
    bit      first;
    case (act)
      ACT_INSERT: begin
        tbl_hits[ia]  = '0;
        tbl_times[ia] = now;
        tbl_sizes[ia] = sz;
      end
      ACT_HIT: begin
        if (tbl_hits[ia] != CNT_MAX) tbl_hits[ia] = tbl_hits[ia] + 1;
      end
      ACT_COMPARE: begin
        first = keeps_first(tbl_hits[ia], entry_den(ia, now),
                            tbl_hits[ib], entry_den(ib, now));
        v.victim = first ? ia : ib;
        v.first  = first;
        victim_q.push_back(v);
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus generation ----------------
  task automatic add_req(bit drain, logic [ACT_W-1:0] act, logic [TIME_W-1:0] now,
                         logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                         logic [SIZE_W-1:0] sz);
    req_t r;
    r.drain  = drain;
    r.action = act;
    r.now    = now;
    r.idx_a  = ia;
    r.idx_b  = ib;
    r.size   = sz;
    req_q.push_back(r);
    if (!drain && act == ACT_INSERT && !gen_written[ia]) begin
      gen_written[ia] = 1'b1;
      live_idx.push_back(ia);
    end
  endtask

  function automatic logic [IDX_W-1:0] hot_idx();
    logic [IDX_W-1:0] k;
    k = IDX_W'($urandom_range(0, 11));
    return $urandom_range(0, 1) ? k : IDX_W'(ENTRIES - 1) - k;
  endfunction

  // a hot entry when written and three times in four, else any written entry
  function automatic logic [IDX_W-1:0] live_pick();
    logic [IDX_W-1:0] c;
    c = hot_idx();
    if (!gen_written[c] || $urandom_range(0, 3) == 0)
      c = live_idx[$urandom_range(0, live_idx.size() - 1)];
    return c;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int m;
    m = $urandom_range(0, 9);
    if (m == 0) return '0;
    if (m == 1) return '1;
    if (m < 6)  return SIZE_W'($urandom_range(1, 16));
    return SIZE_W'($urandom);
  endfunction

  function automatic int gap_len();
    int m;
    m = $urandom_range(0, 19);
    if (m < 14) return 0;
    if (m < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    logic [TIME_W-1:0] gen_now;
    int                sel;
    int                step;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = '0;
    in_ch.clock_now    = '0;
    in_ch.index_a      = '0;
    in_ch.index_b      = '0;
    in_ch.item_size    = '0;
    out_ch.ready       = 1'b0;

    // directed: both-NaN, inf vs NaN, two infinities, finite order,
    // inf vs finite both ways, age wrap, tie, self compare, unused action
    add_req(0, ACT_INSERT,  32'd100, 10'd0,    10'd0,    24'd1);
    add_req(0, ACT_INSERT,  32'd100, 10'd1023, 10'd0,    24'hFFFFFF);
    add_req(0, ACT_COMPARE, 32'd100, 10'd0,    10'd1023, 24'd0);
    add_req(0, ACT_HIT,     32'd100, 10'd0,    10'd0,    24'd0);
    add_req(0, ACT_COMPARE, 32'd100, 10'd0,    10'd1023, 24'd0);
    add_req(0, ACT_HIT,     32'd100, 10'd1023, 10'd0,    24'd0);
    add_req(0, ACT_COMPARE, 32'd100, 10'd0,    10'd1023, 24'd0);
    add_req(0, ACT_COMPARE, 32'd200, 10'd0,    10'd1023, 24'd0);
    add_req(0, ACT_COMPARE, 32'd200, 10'd1023, 10'd0,    24'd0);
    add_req(0, ACT_INSERT,  32'hFFFFFFFF, 10'd5, 10'd0,  24'd0);
    add_req(0, ACT_HIT,     32'd0,   10'd5,    10'd0,    24'd0);
    add_req(0, ACT_COMPARE, 32'd50,  10'd5,    10'd0,    24'd0);
    add_req(0, ACT_COMPARE, 32'd50,  10'd0,    10'd5,    24'd0);
    add_req(0, ACT_INSERT,  32'hFFFFFFF0, 10'h2AA, 10'd0, 24'hFFFFFF);
    add_req(0, ACT_HIT,     32'd0,   10'h2AA,  10'd0,    24'd0);
    add_req(0, ACT_INSERT,  32'hFFFFFFF0, 10'h155, 10'd0, 24'hFFFFFF);
    add_req(0, ACT_HIT,     32'd0,   10'h155,  10'd0,    24'd0);
    add_req(0, ACT_COMPARE, 32'h10,  10'h2AA,  10'h155,  24'd0);
    add_req(0, ACT_COMPARE, 32'h10,  10'h155,  10'h155,  24'd0);
    add_req(0, ACT_INSERT,  32'd0,   10'd9,    10'h3FF,  24'hABCDEF);
    add_req(0, ACT_COMPARE, 32'd0,   10'd9,    10'h2AA,  24'd0);
    add_req(0, ACT_COMPARE, 32'hFFFFFFFF, 10'd9, 10'h2AA, 24'd0);
    add_req(0, ACT_UNUSED,  32'hFFFFFFFF, 10'h3FF, 10'h3FF, 24'hFFFFFF);
    add_req(1, ACT_UNUSED,  32'd0,   10'd0,    10'd0,    24'd0);

    gen_now = 32'hFFFF_F000;
    for (int i = 0; i < 1950; i++) begin
      if (i % 450 == 449) add_req(1, ACT_UNUSED, '0, '0, '0, '0);
      step = $urandom_range(0, 99);
      if (step < 5)       gen_now = gen_now + TIME_W'($urandom);
      else if (step < 80) gen_now = gen_now + TIME_W'($urandom_range(0, 3));
      else                gen_now = gen_now + TIME_W'($urandom_range(4, 5000));
      sel = $urandom_range(0, 99);
      if (sel < 25)
        add_req(0, ACT_INSERT, gen_now,
                ($urandom_range(0, 2) == 0) ? IDX_W'($urandom) : hot_idx(),
                IDX_W'($urandom), rand_size());
      else if (sel < 55)
        add_req(0, ACT_HIT, gen_now, live_pick(), IDX_W'($urandom),
                SIZE_W'($urandom));
      else if (sel < 96)
        add_req(0, ACT_COMPARE, gen_now, live_pick(), live_pick(),
                SIZE_W'($urandom));
      else
        add_req(0, ACT_UNUSED, TIME_W'($urandom), IDX_W'($urandom),
                IDX_W'($urandom), SIZE_W'($urandom));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // ---------------- request driver ----------------
  always @(negedge clk) begin
    req_t r;
    bit   quiet;
    quiet = (cyc_cnt[9:8] == 2'b00);
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !req_taken) begin
      // hold until taken
    end else if (hold_left > 0) begin
      in_ch.valid <= 1'b0;
      hold_left = hold_left - 1;
    end else if (drain_wait) begin
      in_ch.valid <= 1'b0;
      if (victim_q.size() == 0) drain_wait = 1'b0;
    end else if (req_q.size() > 0) begin
      r = req_q.pop_front();
      if (r.drain) begin
        in_ch.valid <= 1'b0;
        drain_wait = 1'b1;
      end else begin
        in_ch.valid     <= 1'b1;
        in_ch.action    <= r.action;
        in_ch.clock_now <= r.now;
        in_ch.index_a   <= r.idx_a;
        in_ch.index_b   <= r.idx_b;
        in_ch.item_size <= r.size;
        hold_left = quiet ? 0 : gap_len();
      end
    end else begin
      in_ch.valid <= 1'b0;
      stim_done = 1'b1;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (cyc_cnt[9:8] != 2'b00 && $urandom_range(0, 3) == 0) stall_left = gap_len();
    end
  end

  // ---------------- monitor / checker ----------------
  always @(posedge clk) begin
    victim_t want;
    cyc_cnt   = cyc_cnt + 1;
    req_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (victim_q.size() == 0) begin
          $display("%0t: unexpected result victim_index=%0d picked_first=%0b",
                   $time, out_ch.victim_index, out_ch.picked_first);
          err_cnt = err_cnt + 1;
        end else begin
          want = victim_q.pop_front();
          if (out_ch.victim_index !== want.victim) begin
            $display("%0t: victim_index mismatch: expected %0d, got %0d",
                     $time, want.victim, out_ch.victim_index);
            err_cnt = err_cnt + 1;
          end
          if (out_ch.picked_first !== want.first) begin
            $display("%0t: picked_first mismatch: expected %0b, got %0b",
                     $time, want.first, out_ch.picked_first);
            err_cnt = err_cnt + 1;
          end
        end
      end
      if (req_taken)
        apply_request(in_ch.action, in_ch.clock_now, in_ch.index_a,
                      in_ch.index_b, in_ch.item_size);
    end
  end

  initial begin
    @(posedge rst_n);
    while (!(stim_done && victim_q.size() == 0)) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("timeout: %0d requests left, %0d results outstanding",
             req_q.size(), victim_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
src/her_pkg.sv
src/her_in_if.sv
src/her_out_if.sv
src/her_ctrl.sv
src/her_dp.sv
src/hyperbolic_eviction_ranker_top.sv
tb/sv/tb_hyperbolic_eviction_ranker_top.sv
